// ===== sv/eipl4_pkg.sv =====
// Shared types and constants for the Ethernet/IPv4/L4 header extractor.
package eipl4_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [2:0] ST_NOT_V4    = 3'd3;
  localparam logic [2:0] ST_NOT_L4    = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  // One input beat: a frame byte and its end-of-frame mark.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } byte_beat_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  ip_proto;
    logic [15:0] payload_offset;
    logic [15:0] payload_len;
  } result_beat_t;

  // Everything latched for one frame, handed from the front to the back.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] ip_total_length;
    logic [7:0]  proto;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  tcp_offset;
  } frame_rec_t;

endpackage

// ===== sv/eipl4_front.sv =====
// Front end: counts frame bytes and latches header fields at their offsets.
module eipl4_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_ready,
  input  eipl4_pkg::byte_beat_t    byte_beat,
  output logic                     rec_push,
  output eipl4_pkg::frame_rec_t    rec_data,
  input  logic                     rec_full
);

  logic [15:0] byte_index, byte_index_next;
  logic [15:0] ether_type, ether_type_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] ip_total_length, ip_total_length_next;
  logic [7:0]  proto_reg, proto_reg_next;
  logic [31:0] sip_reg, sip_reg_next;
  logic [31:0] dip_reg, dip_reg_next;
  logic [15:0] sport_reg, sport_reg_next;
  logic [15:0] dport_reg, dport_reg_next;
  logic [7:0]  tcp_offset_reg, tcp_offset_reg_next;

  logic        take;
  logic [7:0]  b;
  logic [15:0] count;
  logic [3:0]  ihl_eff;
  logic [15:0] l4;

  assign byte_ready = !rec_full;
  assign take       = byte_valid && byte_ready;
  assign b          = byte_beat.frame_byte;
  assign count      = (byte_index == 16'hffff) ? byte_index : byte_index + 16'd1;

  // The IHL byte counts for placing L4 bytes on the very beat it arrives.
  assign ihl_eff = (byte_index == 16'd14) ? b[3:0] : version_ihl[3:0];
  assign l4      = 16'd14 + {10'd0, ihl_eff, 2'b00};

  always_comb begin
    ether_type_next      = ether_type;
    version_ihl_next     = version_ihl;
    ip_total_length_next = ip_total_length;
    proto_reg_next       = proto_reg;
    sip_reg_next         = sip_reg;
    dip_reg_next         = dip_reg;
    sport_reg_next       = sport_reg;
    dport_reg_next       = dport_reg;
    tcp_offset_reg_next  = tcp_offset_reg;
    if (byte_index == 16'd12 || byte_index == 16'd13) begin
      ether_type_next = {ether_type[7:0], b};
    end
    if (byte_index == 16'd14) begin
      version_ihl_next = b;
    end
    if (byte_index == 16'd16 || byte_index == 16'd17) begin
      ip_total_length_next = {ip_total_length[7:0], b};
    end
    if (byte_index == 16'd23) begin
      proto_reg_next = b;
    end
    if (byte_index >= 16'd26 && byte_index <= 16'd29) begin
      sip_reg_next = {sip_reg[23:0], b};
    end
    if (byte_index >= 16'd30 && byte_index <= 16'd33) begin
      dip_reg_next = {dip_reg[23:0], b};
    end
    if (byte_index >= 16'd14) begin
      if (byte_index == l4 || byte_index == l4 + 16'd1) begin
        sport_reg_next = {sport_reg[7:0], b};
      end
      if (byte_index == l4 + 16'd2 || byte_index == l4 + 16'd3) begin
        dport_reg_next = {dport_reg[7:0], b};
      end
      if (byte_index == l4 + 16'd12) begin
        tcp_offset_reg_next = b;
      end
    end
    byte_index_next = count;
  end

  assign rec_push = take && byte_beat.last_byte;

  always_comb begin
    rec_data.frame_len       = count;
    rec_data.ether_type      = ether_type_next;
    rec_data.version_ihl     = version_ihl_next;
    rec_data.ip_total_length = ip_total_length_next;
    rec_data.proto           = proto_reg_next;
    rec_data.ip_src          = sip_reg_next;
    rec_data.ip_dst          = dip_reg_next;
    rec_data.sport           = sport_reg_next;
    rec_data.dport           = dport_reg_next;
    rec_data.tcp_offset      = tcp_offset_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      byte_index      <= '0;
      ether_type      <= '0;
      version_ihl     <= '0;
      ip_total_length <= '0;
      proto_reg       <= '0;
      sip_reg         <= '0;
      dip_reg         <= '0;
      sport_reg       <= '0;
      dport_reg       <= '0;
      tcp_offset_reg  <= '0;
    end else if (take) begin
      byte_index      <= byte_index_next;
      ether_type      <= ether_type_next;
      version_ihl     <= version_ihl_next;
      ip_total_length <= ip_total_length_next;
      proto_reg       <= proto_reg_next;
      sip_reg         <= sip_reg_next;
      dip_reg         <= dip_reg_next;
      sport_reg       <= sport_reg_next;
      dport_reg       <= dport_reg_next;
      tcp_offset_reg  <= tcp_offset_reg_next;
    end
  end

endmodule

// ===== sv/eipl4_queue.sv =====
// Two-entry register queue of frame records between front and back.
module eipl4_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  eipl4_pkg::frame_rec_t push_data,
  output logic                  full,
  output logic                  not_empty,
  input  logic                  pop,
  output eipl4_pkg::frame_rec_t pop_data
);

  eipl4_pkg::frame_rec_t entries [eipl4_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'(eipl4_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== sv/eipl4_back.sv =====
// Back end: checks a frame record, works out payload offset and length, and
// holds the result in an output register.
module eipl4_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rec_valid,
  output logic                     rec_pop,
  input  eipl4_pkg::frame_rec_t    rec,
  output logic                     result_valid,
  input  logic                     result_ready,
  output eipl4_pkg::result_beat_t  result_beat
);

  logic [15:0] len;
  logic [15:0] ip_size;
  logic [15:0] l4;
  logic [15:0] need;
  logic [15:0] tcp_len;
  logic [15:0] off;
  logic [15:0] plen;
  logic [2:0]  status;
  logic        is_tcp;
  logic        is_udp;
  eipl4_pkg::result_beat_t res;

  assign len     = rec.frame_len;
  assign ip_size = {10'd0, rec.version_ihl[3:0], 2'b00};
  assign l4      = 16'd14 + ip_size;
  assign need    = 16'd14 + ((ip_size < 16'd20) ? 16'd20 : ip_size);
  assign tcp_len = {10'd0, rec.tcp_offset[7:4], 2'b00};
  assign is_tcp  = (rec.proto == eipl4_pkg::PROTO_TCP);
  assign is_udp  = (rec.proto == eipl4_pkg::PROTO_UDP);

  always_comb begin
    if (is_tcp) begin
      off  = l4 + tcp_len;
      plen = len - 16'd14 - ip_size - tcp_len;
    end else begin
      off  = l4 + 16'd8;
      plen = rec.ip_total_length - ip_size - 16'd8;
    end
  end

  // Checks in priority order; the first that fails sets the status.
  always_comb begin
    if (len < 16'd15) begin
      status = eipl4_pkg::ST_SHORT;
    end else if (rec.ether_type != eipl4_pkg::ETHERTYPE_IPV4) begin
      status = eipl4_pkg::ST_NOT_IPV4;
    end else if (rec.version_ihl[7:4] != eipl4_pkg::IP_VERSION_4) begin
      status = eipl4_pkg::ST_NOT_V4;
    end else if (len < need) begin
      status = eipl4_pkg::ST_SHORT;
    end else if (!is_tcp && !is_udp) begin
      status = eipl4_pkg::ST_NOT_L4;
    end else if (is_tcp && len < l4 + 16'd13) begin
      status = eipl4_pkg::ST_SHORT;
    end else if (is_udp && len < l4 + 16'd8) begin
      status = eipl4_pkg::ST_SHORT;
    end else if (len < off) begin
      status = eipl4_pkg::ST_SHORT;
    end else begin
      status = eipl4_pkg::ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == eipl4_pkg::ST_OK) begin
      res.src_ip         = rec.ip_src;
      res.dst_ip         = rec.ip_dst;
      res.l4_sport       = rec.sport;
      res.l4_dport       = rec.dport;
      res.ip_proto       = rec.proto;
      res.payload_offset = off;
      res.payload_len    = plen;
    end
  end

  assign rec_pop = rec_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rec_pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      result_beat <= res;
    end
  end

endmodule

// ===== sv/eth_ipv4_l4_header_extractor.sv =====
// Top level of the Ethernet/IPv4/TCP-UDP header extractor.
//
//   Channel   Direction  Handshake                   Payload
//   byte      in         byte_valid / byte_ready     byte_beat (byte_beat_t)
//   result    out        result_valid / result_ready result_beat (result_beat_t)
//
// The front end takes one byte beat per cycle while the queue is not full,
// and latches header fields at their offsets; the L4 header is placed at
// 14 + IHL*4 bytes. On the last byte of a frame the latched fields go into
// a two-entry queue as that beat is taken, and the back end moves the
// oldest record into its output register, which drives result_valid, once
// that register is empty or its result is being taken.
// A frame of any length yields exactly one result beat.
// Reset (rst, synchronous) empties the queue and the output register and
// clears the byte count and latched fields.
// byte_ready drops only while the queue holds two frame records, which takes
// a stalled result side and at least three finished frames.
module eth_ipv4_l4_header_extractor (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_ready,
  input  eipl4_pkg::byte_beat_t    byte_beat,
  output logic                     result_valid,
  input  logic                     result_ready,
  output eipl4_pkg::result_beat_t  result_beat
);

  logic                  rec_push;
  logic                  rec_full;
  logic                  rec_valid;
  logic                  rec_pop;
  eipl4_pkg::frame_rec_t rec_in;
  eipl4_pkg::frame_rec_t rec_out;

  eipl4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .rec_push   (rec_push),
    .rec_data   (rec_in),
    .rec_full   (rec_full)
  );

  // Frame records wait here so byte intake keeps going while results stall.
  eipl4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_data (rec_in),
    .full      (rec_full),
    .not_empty (rec_valid),
    .pop       (rec_pop),
    .pop_data  (rec_out)
  );

  eipl4_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (rec_valid),
    .rec_pop      (rec_pop),
    .rec          (rec_out),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

endmodule

// ===== bench/eth_ipv4_l4_header_extractor_tb.sv =====
// Self-checking testbench for the Ethernet/IPv4/TCP-UDP header extractor.
module eth_ipv4_l4_header_extractor_tb;

  // Clock, reset and the two channels. Every input starts at a known value.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    byte_valid = 1'b0;
  logic                    byte_ready;
  eipl4_pkg::byte_beat_t   byte_beat = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  eipl4_pkg::result_beat_t result_beat;

  eth_ipv4_l4_header_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Header fields that the block should report, oldest frame first.
  eipl4_pkg::result_beat_t frame_headers[$];

  // Bytes of the frame under construction; send_frame streams them out.
  logic [7:0]   frame_buf[$];

  // Shadow copy of the parser state, updated on every accepted byte beat.
  logic [15:0]  frame_pos;
  logic [15:0]  sh_ether_type;
  logic [7:0]   sh_ver_ihl;
  logic [15:0]  sh_total_len;
  logic [7:0]   sh_proto;
  logic [31:0]  sh_src_ip;
  logic [31:0]  sh_dst_ip;
  logic [15:0]  sh_sport;
  logic [15:0]  sh_dport;
  logic [7:0]   sh_tcp_off;

  // Traffic shaping knobs shared between the tests and the two drivers.
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  int           burst_left = 0;
  int           hold_cycles = 0;

  // Bookkeeping for the closing summary and the verdict.
  int           errors = 0;
  int           bytes_sent = 0;
  int           frames_sent = 0;
  int           results_seen = 0;
  int           status_tally[5] = '{default: 0};

  eipl4_pkg::result_beat_t got_hdr;
  eipl4_pkg::result_beat_t want_hdr;

  task automatic clear_shadow();
    frame_pos     = '0;
    sh_ether_type = '0;
    sh_ver_ihl    = '0;
    sh_total_len  = '0;
    sh_proto      = '0;
    sh_src_ip     = '0;
    sh_dst_ip     = '0;
    sh_sport      = '0;
    sh_dport      = '0;
    sh_tcp_off    = '0;
  endtask

  // Works out the verdict for a finished frame of len bytes from the latched
  // fields. Checks run in a fixed order, and an error zeroes every field but
  // the status.
  function automatic eipl4_pkg::result_beat_t judge_frame(input int len);
    eipl4_pkg::result_beat_t r;
    int           ip_size;
    int           l4;
    int           need;
    int           tcp_len;
    int           off;
    int           plen;
    logic [2:0]   st;
    r       = '0;
    off     = 0;
    plen    = 0;
    ip_size = int'(sh_ver_ihl[3:0]) * 4;
    l4      = 14 + ip_size;
    need    = 14 + ((ip_size < 20) ? 20 : ip_size);
    if (len < 15) begin
      st = eipl4_pkg::ST_SHORT;
    end else if (sh_ether_type != eipl4_pkg::ETHERTYPE_IPV4) begin
      st = eipl4_pkg::ST_NOT_IPV4;
    end else if (sh_ver_ihl[7:4] != eipl4_pkg::IP_VERSION_4) begin
      st = eipl4_pkg::ST_NOT_V4;
    end else if (len < need) begin
      st = eipl4_pkg::ST_SHORT;
    end else if (sh_proto != eipl4_pkg::PROTO_TCP && sh_proto != eipl4_pkg::PROTO_UDP) begin
      st = eipl4_pkg::ST_NOT_L4;
    end else if (sh_proto == eipl4_pkg::PROTO_TCP) begin
      if (len < l4 + 13) begin
        st = eipl4_pkg::ST_SHORT;
      end else begin
        // TCP payload length comes from the frame size, so it may wrap.
        tcp_len = int'(sh_tcp_off[7:4]) * 4;
        off     = l4 + tcp_len;
        plen    = len - 14 - ip_size - tcp_len;
        st      = (len < off) ? eipl4_pkg::ST_SHORT : eipl4_pkg::ST_OK;
      end
    end else begin
      if (len < l4 + 8) begin
        st = eipl4_pkg::ST_SHORT;
      end else begin
        // UDP payload length trusts the IP total length field instead.
        off  = l4 + 8;
        plen = int'(sh_total_len) - ip_size - 8;
        st   = (len < off) ? eipl4_pkg::ST_SHORT : eipl4_pkg::ST_OK;
      end
    end
    r.status = st;
    if (st == eipl4_pkg::ST_OK) begin
      r.src_ip         = sh_src_ip;
      r.dst_ip         = sh_dst_ip;
      r.l4_sport       = sh_sport;
      r.l4_dport       = sh_dport;
      r.ip_proto       = sh_proto;
      r.payload_offset = off[15:0];
      r.payload_len    = plen[15:0];
    end
    return r;
  endfunction

  // Latches one accepted byte into the shadow state. The L4 start uses the
  // IHL as it stands after this byte, which matters for the byte at 14.
  task automatic parse_frame_byte(input logic [7:0] b, input logic lst);
    int idx;
    int count;
    int l4;
    idx   = int'(frame_pos);
    count = (idx >= 65535) ? 65535 : idx + 1;
    if (idx == 12 || idx == 13) sh_ether_type = {sh_ether_type[7:0], b};
    if (idx == 14) sh_ver_ihl = b;
    if (idx == 16 || idx == 17) sh_total_len = {sh_total_len[7:0], b};
    if (idx == 23) sh_proto = b;
    if (idx >= 26 && idx <= 29) sh_src_ip = {sh_src_ip[23:0], b};
    if (idx >= 30 && idx <= 33) sh_dst_ip = {sh_dst_ip[23:0], b};
    if (idx >= 14) begin
      l4 = 14 + int'(sh_ver_ihl[3:0]) * 4;
      if (idx == l4 || idx == l4 + 1) sh_sport = {sh_sport[7:0], b};
      if (idx == l4 + 2 || idx == l4 + 3) sh_dport = {sh_dport[7:0], b};
      if (idx == l4 + 12) sh_tcp_off = b;
    end
    if (!lst) begin
      frame_pos = count[15:0];
    end else begin
      frame_headers.push_back(judge_frame(count));
      clear_shadow();
    end
  endtask

  // Offers one byte beat. The sender works in bursts; a new burst may start
  // after a random gap with valid low. Once valid is up it stays up, with the
  // same payload, until the block takes the beat.
  task automatic send_beat(input logic [7:0] b, input logic lst);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_beat  <= '{frame_byte: b, last_byte: lst};
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    parse_frame_byte(b, lst);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_beat(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    byte_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Builds a well-formed frame in frame_buf: random MACs, IPv4 EtherType,
  // version 4 with the given IHL, a consistent total length, and an L4 header
  // at 14 + IHL*4 followed by pay_len payload bytes. With a small IHL the
  // fixed IP fields are written last and may land on top of L4 bytes.
  task automatic build_frame(input logic [7:0] proto, input int ihl, input int doff,
                             input int pay_len);
    int l4;
    int hdr;
    int n;
    int total;
    l4    = 14 + ihl * 4;
    hdr   = (proto == eipl4_pkg::PROTO_TCP) ? ((doff * 4 < 13) ? 13 : doff * 4) : 8;
    n     = l4 + hdr + pay_len;
    if (n < 34) n = 34;
    total = ihl * 4 + ((proto == eipl4_pkg::PROTO_TCP) ? doff * 4 : 8) + pay_len;
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom));
    if (proto == eipl4_pkg::PROTO_TCP)
      frame_buf[l4 + 12] = {4'(doff), 4'($urandom)};
    frame_buf[12] = eipl4_pkg::ETHERTYPE_IPV4[15:8];
    frame_buf[13] = eipl4_pkg::ETHERTYPE_IPV4[7:0];
    frame_buf[14] = {eipl4_pkg::IP_VERSION_4, 4'(ihl)};
    frame_buf[16] = total[15:8];
    frame_buf[17] = total[7:0];
    frame_buf[23] = proto;
  endtask

  task automatic truncate_frame(input int n);
    while (frame_buf.size() > n) void'(frame_buf.pop_back());
  endtask

  // Field comparison shared by every check of a result beat.
  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checker: every accepted result beat is matched against the
  // oldest predicted header. Sampling at the rising edge sees pre-edge values.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_hdr = result_beat;
      results_seen++;
      if (got_hdr.status <= eipl4_pkg::ST_NOT_L4) status_tally[got_hdr.status]++;
      if (frame_headers.size() == 0) begin
        $error("result beat with no frame pending (status %0d)", got_hdr.status);
        errors++;
      end else begin
        want_hdr = frame_headers.pop_front();
        compare_field("status",         32'(want_hdr.status),         32'(got_hdr.status));
        compare_field("src_ip",         want_hdr.src_ip,              got_hdr.src_ip);
        compare_field("dst_ip",         want_hdr.dst_ip,              got_hdr.dst_ip);
        compare_field("l4_sport",       32'(want_hdr.l4_sport),       32'(got_hdr.l4_sport));
        compare_field("l4_dport",       32'(want_hdr.l4_dport),       32'(got_hdr.l4_dport));
        compare_field("ip_proto",       32'(want_hdr.ip_proto),       32'(got_hdr.ip_proto));
        compare_field("payload_offset", 32'(want_hdr.payload_offset),
                      32'(got_hdr.payload_offset));
        compare_field("payload_len",    32'(want_hdr.payload_len),
                      32'(got_hdr.payload_len));
      end
    end
  end

  // Result sink. It alternates ready runs with short or medium stalls, and
  // when a test asks for a hold-off it keeps ready low for the whole hold-off,
  // counted here from hold_cycles, while the sender keeps offering bytes.
  initial begin : result_sink
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (run_left > 0) begin
        result_ready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        run_left = $urandom_range(1, 24);
        if (rx_steady) stall_left = 0;
        else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(0, 3);
        result_ready <= 1'b1;
      end
    end
  end

  // Frames shorter than 15 bytes are too short before anything else is
  // looked at; 15 bytes with a good EtherType fail the IP header length.
  task automatic test_tiny_frames();
    frame_buf.delete();
    frame_buf.push_back(8'hff);
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 5, 0);
    truncate_frame(14);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 0);
    truncate_frame(15);
    send_frame();
  endtask

  // Wrong EtherType, wrong version, short IP header and foreign protocols.
  task automatic test_header_faults();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 5, 4);
    frame_buf[12] = 8'h86;
    frame_buf[13] = 8'hdd;
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 5, 4);
    frame_buf[14] = 8'h65;
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 0);
    truncate_frame(33);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 8, 5, 0);
    truncate_frame(14 + 32 - 1);
    send_frame();
    build_frame(8'h01, 5, 5, 8);
    send_frame();
    build_frame(8'hff, 5, 5, 0);
    send_frame();
  endtask

  // L4 header bounds: one byte short of and exactly at the TCP offset byte
  // and the UDP header end, and a TCP data offset reaching past the frame.
  task automatic test_l4_bounds();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 0, 0);
    truncate_frame(34 + 12);
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 0, 0);
    truncate_frame(34 + 13);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 0);
    truncate_frame(34 + 7);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 0);
    truncate_frame(34 + 8);
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 15, 0);
    truncate_frame(34 + 20);
    send_frame();
  endtask

  // Odd but accepted headers: IHL below five so ports overlap IP fields,
  // the largest IHL, a zero data offset, and UDP total lengths of zero (the payload length wraps) and all ones.
  task automatic test_odd_headers();
    build_frame(eipl4_pkg::PROTO_TCP, 0, 5, 6);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 3, 5, 2);
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 15, 5, 3);
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 0, 5);
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 4);
    frame_buf[16] = 8'h00;
    frame_buf[17] = 8'h00;
    send_frame();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 4);
    frame_buf[16] = 8'hff;
    frame_buf[17] = 8'hff;
    send_frame();
  endtask

  // Addresses and ports at all ones and all zeros.
  task automatic test_extreme_bytes();
    build_frame(eipl4_pkg::PROTO_UDP, 5, 5, 2);
    for (int i = 26; i < 42; i++) frame_buf[i] = 8'hff;
    send_frame();
    build_frame(eipl4_pkg::PROTO_TCP, 5, 5, 2);
    for (int i = 0; i < 12; i++) frame_buf[i] = 8'h00;
    for (int i = 26; i < 38; i++) frame_buf[i] = 8'h00;
    send_frame();
  endtask

  // The sink holds off for a long stretch while single-byte and short
  // frames keep coming, so the record queue fills and byte_ready drops.
  task automatic test_result_backpressure();
    tx_steady   = 1'b1;
    hold_cycles = 300;
    repeat (10) begin
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      send_frame();
    end
    repeat (3) begin
      build_frame(eipl4_pkg::PROTO_UDP, 5, 5, $urandom_range(0, 4));
      send_frame();
    end
    tx_steady = 1'b0;
  endtask

  // Mostly well-formed TCP/UDP frames with random content, plus damaged
  // frames, raw noise and frames with random length fields.
  task automatic test_random_traffic();
    int pick;
    int ihl;
    int doff;
    logic [7:0] proto;
    while (bytes_sent < 1800) begin
      pick      = $urandom_range(0, 99);
      tx_steady = ($urandom_range(0, 7) == 0);
      rx_steady = ($urandom_range(0, 7) == 0);
      proto     = ($urandom_range(0, 1) == 0) ? eipl4_pkg::PROTO_TCP : eipl4_pkg::PROTO_UDP;
      ihl       = $urandom_range(0, 99);
      ihl       = (ihl < 80) ? 5 : (ihl < 95) ? $urandom_range(6, 15) : $urandom_range(0, 4);
      doff      = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
      if (pick < 85) build_frame(proto, ihl, doff, $urandom_range(0, 24));
      if (pick >= 55 && pick < 70) begin
        case ($urandom_range(0, 3))
          0: truncate_frame($urandom_range(1, frame_buf.size()));
          1: frame_buf[$urandom_range(12, 13)] = 8'($urandom);
          2: frame_buf[14] = {4'($urandom), frame_buf[14][3:0]};
          default: frame_buf[23] = 8'($urandom);
        endcase
      end else if (pick >= 70 && pick < 85) begin
        frame_buf[16] = 8'($urandom);
        frame_buf[17] = 8'($urandom);
      end else if (pick >= 85) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
      end
      send_frame();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Run-time cap, reckoned from the slowest correct run with a wide margin.
  initial begin
    #20000000;
    $display("** eth_ipv4_l4_header_extractor: FAILED **");
    $finish;
  end

  initial begin
    clear_shadow();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_tiny_frames();
    test_header_faults();
    test_l4_bounds();
    test_odd_headers();
    test_extreme_bytes();
    test_result_backpressure();
    test_random_traffic();
    idle_sender();

    // Drain: wait for every predicted header, then keep watching so a
    // stray extra result beat would still be caught.
    while (frame_headers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frames in %0d byte beats; checked %0d result beats.",
             frames_sent, bytes_sent, results_seen);
    $display("Status mix: ok %0d, short %0d, bad ethertype %0d, bad version %0d, not L4 %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (errors == 0 && frame_headers.size() == 0) begin
      $display("** eth_ipv4_l4_header_extractor: PASSED **");
    end else begin
      $display("** eth_ipv4_l4_header_extractor: FAILED **");
    end
    $finish;
  end

endmodule
